// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, skipped while reset is low.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds at the next edge.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sadv_pkg.sv -----
package sadv_pkg;

  localparam int unsigned CalibSamples = 64;
  localparam int unsigned ButtonCount  = 16;

  // Noise calibration limits, in units of 2^-30 and 2^-15.
  localparam logic [33:0] NoiseSqLimit = 34'd107374;
  localparam logic [16:0] FakePeak     = 17'd655;

  localparam logic [1:0] RegGain  = 2'd0;
  localparam logic [1:0] RegSlack = 2'd1;
  localparam logic [1:0] RegClamp = 2'd2;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] axis_rx;
    logic signed [15:0] axis_ry;
    logic signed [15:0] axis_rz;
    logic [31:0]        stamp;
    logic [15:0]        button_levels;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic signed [31:0] turn_x;
    logic signed [31:0] turn_y;
    logic signed [31:0] turn_z;
    logic [31:0]        turn_rate;
    logic               stick_ok;
    logic               rotation_ok;
    logic [15:0]        button_presses;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_AXIS,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_TR_START,
    ST_TR_WAIT,
    ST_TRSQ_START,
    ST_TRSQ_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

endpackage

// ----- hw/rtl/sadv_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle; unsigned operands.
module sadv_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            busy,
  output logic [AW+BW-1:0] prod
);
  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW+BW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0]    mplier_r, mplier_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = {{BW{1'b0}}, a};
      mplier_nxt = b;
      cnt_nxt    = CW'(BW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;
endmodule

// ----- hw/rtl/sadv_div.sv -----
// Restoring divider, one quotient bit per cycle; unsigned.
module sadv_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      d_nxt    = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

// ----- hw/rtl/sadv_sqrt.sv -----
// Integer square root, one result bit (two radicand bits) per cycle.
module sadv_sqrt #(
  parameter int unsigned RW = 66
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   rad,
  output logic            busy,
  output logic [RW/2-1:0] root
);
  localparam int unsigned HW = RW / 2;
  localparam int unsigned CW = $clog2(HW + 1);

  logic [RW-1:0] v_r, v_nxt;
  logic [HW+1:0] rem_r, rem_nxt;
  logic [HW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [HW+1:0] trial, sub;

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[HW-1:0], v_r[RW-1 -: 2]};
    sub      = {q_r, 2'b01};
    if (start) begin
      v_nxt    = rad;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CW'(HW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = v_r << 2;
      if (trial >= sub) begin
        rem_nxt = trial - sub;
        q_nxt   = {q_r[HW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[HW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r   <= v_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign root = q_r;
endmodule

// ----- hw/rtl/six_axis_deadband_velocity.sv -----
// Six-axis deadband velocity block.
// Input channel in_valid/in_stall carries one sample beat: six Q1.15 axes,
// a tick stamp and button levels. Result channel out_valid/out_stall carries
// six saturated rates, the rotation rate norm, ok flags and button presses.
// Config: cfg_we/cfg_index/cfg_data, index 0 gain, 1 slack, 2 clamp; write
// only while idle.
// The first CAL_SAMPLES beats calibrate the noise floor and give no result;
// after the last, the squares and the root are worked out before the next
// beat can be taken. Later beats give one result each, out_valid rising
// once the bit-serial multiplier, divider and root unit, shared across the
// axes, have worked through the sample; one beat is in flight at a time,
// the next taken once the result is loaded and the block is back in idle.
// The result sits in an output register; while the receiver stalls it the
// next beat is still taken and worked on, but holds before loading its
// result until the register is free, and in_stall stays high meanwhile.
// Reset (synchronous, rst_n low) clears calibration, the stamp history,
// the button history and restores the register defaults; in_stall is high
// while rst_n is low.
`include "assert_macros.svh"
module six_axis_deadband_velocity #(
  parameter int unsigned CAL_SAMPLES = sadv_pkg::CalibSamples,
  parameter int unsigned BTN_COUNT   = sadv_pkg::ButtonCount
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sadv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sadv_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  localparam int unsigned CCW = $clog2(CAL_SAMPLES + 1);
  localparam logic [15:0] BtnMask = 16'((33'd1 << BTN_COUNT) - 33'd1);
  localparam logic [33:0] FakeSq  =
    34'd6 * 34'(sadv_pkg::FakePeak) * 34'(sadv_pkg::FakePeak);

  sadv_pkg::state_t state_r, state_nxt;

  logic [15:0] gain_r;
  logic [2:0]  slack_r, clamp_r;
  logic [15:0] peak_r [6];
  logic [CCW-1:0] calib_r;
  logic [16:0] norm_r;
  logic [31:0] pstamp_r;
  logic        seen_r;
  logic [15:0] pbtn_r;

  sadv_pkg::in_item_t  item_r;
  sadv_pkg::out_item_t res_r;
  logic        ovalid_r;
  logic [2:0]  ax_r;
  logic [33:0] sq_acc_r;
  logic [65:0] tr_acc_r;
  logic [31:0] dt_r;
  logic        neg_r, passed_r, rot_r;
  logic [31:0] rate_r [6];

  // shared units
  logic        mul_start, div_start, sq_start;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        mul_busy, div_busy, sq_busy;
  logic [47:0] div_num, div_q;
  logic [65:0] sq_rad;
  logic [32:0] sq_root;

  sadv_mul #(.AW(32), .BW(32)) u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(mul_p));
  sadv_div #(.NW(48), .DW(32)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(dt_r),
    .busy(div_busy), .quo(div_q));
  sadv_sqrt #(.RW(66)) u_sqrt (
    .clk, .rst_n, .start(sq_start), .rad(sq_rad),
    .busy(sq_busy), .root(sq_root));

  logic signed [15:0] cur_ax;
  logic [15:0] cur_mag, cur_peak;
  logic [19:0] thresh;
  logic [22:0] limit, fmag;
  logic        pass;
  logic        calib_done;
  logic        accept, last_cal;

  always_comb begin
    case (ax_r)
      3'd0: cur_ax = item_r.axis_x;
      3'd1: cur_ax = item_r.axis_y;
      3'd2: cur_ax = item_r.axis_z;
      3'd3: cur_ax = item_r.axis_rx;
      3'd4: cur_ax = item_r.axis_ry;
      default: cur_ax = item_r.axis_rz;
    endcase
    cur_peak = peak_r[ax_r < 3'd6 ? ax_r : 3'd5];
  end
  assign cur_mag = cur_ax[15] ? 16'(-cur_ax) : 16'(cur_ax);
  assign thresh  = 20'(slack_r) * 20'(norm_r);
  assign limit   = 23'(clamp_r) * 23'(thresh);
  assign pass    = {4'd0, cur_mag} > thresh;
  assign fmag    = !pass ? 23'd0 : (23'(cur_mag) > limit ? limit : 23'(cur_mag));
  assign calib_done = calib_r == CCW'(CAL_SAMPLES);
  assign accept  = in_valid && !in_stall;
  assign last_cal = calib_r == CCW'(CAL_SAMPLES - 1);

  // the multiply in ST_AXIS must finish before the divide; DIV_START waits on it
  logic div_go;
  assign div_go = state_r == sadv_pkg::ST_DIV_START && !mul_busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sadv_pkg::ST_IDLE:
        if (accept) state_nxt = calib_done ? sadv_pkg::ST_AXIS :
                               (last_cal ? sadv_pkg::ST_SQ_START : sadv_pkg::ST_IDLE);
      sadv_pkg::ST_SQ_START:  state_nxt = sadv_pkg::ST_SQ_WAIT;
      sadv_pkg::ST_SQ_WAIT:
        if (!mul_busy && ax_r == 3'd5) state_nxt = sadv_pkg::ST_SQRT_START;
        else if (!mul_busy) state_nxt = sadv_pkg::ST_SQ_START;
      sadv_pkg::ST_SQRT_START: state_nxt = sadv_pkg::ST_SQRT_WAIT;
      sadv_pkg::ST_SQRT_WAIT:
        if (!sq_busy) state_nxt = sadv_pkg::ST_IDLE;
      sadv_pkg::ST_AXIS:      state_nxt = sadv_pkg::ST_DIV_START;
      sadv_pkg::ST_DIV_START:
        if (div_go) state_nxt = sadv_pkg::ST_DIV_WAIT;
      sadv_pkg::ST_DIV_WAIT:
        if (!div_busy && ax_r == 3'd5) state_nxt = sadv_pkg::ST_TR_START;
        else if (!div_busy) state_nxt = sadv_pkg::ST_AXIS;
      sadv_pkg::ST_TR_START:  state_nxt = sadv_pkg::ST_TR_WAIT;
      sadv_pkg::ST_TR_WAIT:
        if (!mul_busy && ax_r == 3'd5) state_nxt = sadv_pkg::ST_TRSQ_START;
        else if (!mul_busy) state_nxt = sadv_pkg::ST_TR_START;
      sadv_pkg::ST_TRSQ_START: state_nxt = sadv_pkg::ST_TRSQ_WAIT;
      sadv_pkg::ST_TRSQ_WAIT:
        if (!sq_busy && !ovalid_r) state_nxt = sadv_pkg::ST_OUT;
      sadv_pkg::ST_OUT:
        if (!ovalid_r || !out_stall) state_nxt = sadv_pkg::ST_IDLE;
      default: state_nxt = sadv_pkg::ST_IDLE;
    endcase
  end

  logic [31:0] rate_mag;
  assign rate_mag = rate_r[ax_r < 3'd6 ? ax_r : 3'd5][31] ?
                    32'(-rate_r[ax_r < 3'd6 ? ax_r : 3'd5]) :
                    rate_r[ax_r < 3'd6 ? ax_r : 3'd5];

  // unit controls
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_rad    = {32'd0, sq_acc_r};
    div_num   = 48'(mul_p);
    unique case (state_r)
      sadv_pkg::ST_SQ_START: begin
        mul_start = 1'b1;
        mul_a = 32'(cur_peak);
        mul_b = 32'(cur_peak);
      end
      sadv_pkg::ST_SQRT_START: begin
        sq_start = 1'b1;
        // quiet stick: root of the substituted peaks
        if (sq_acc_r <= sadv_pkg::NoiseSqLimit) sq_rad = {32'd0, FakeSq};
      end
      sadv_pkg::ST_DIV_START: div_start = div_go && dt_r != 32'd0;
      sadv_pkg::ST_AXIS: begin
        mul_start = 1'b1;
        mul_a = 32'(fmag);
        mul_b = 32'(gain_r);
      end
      sadv_pkg::ST_TR_START: begin
        mul_start = 1'b1;
        mul_a = rate_mag;
        mul_b = rate_mag;
      end
      sadv_pkg::ST_TRSQ_START: begin
        sq_start = 1'b1;
        sq_rad = tr_acc_r;
      end
      default: ;
    endcase
  end

  logic [31:0] sat_rate;
  always_comb begin
    if (dt_r == 32'd0) sat_rate = '0;
    else if (neg_r)
      sat_rate = (div_q > 48'h8000_0000) ? 32'h8000_0000 : 32'(-div_q);
    else
      sat_rate = (div_q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sadv_pkg::ST_IDLE;
      gain_r   <= 16'd1;
      slack_r  <= 3'd2;
      clamp_r  <= 3'd2;
      for (int i = 0; i < 6; i++) peak_r[i] <= '0;
      calib_r  <= '0;
      norm_r   <= '0;
      pstamp_r <= '0;
      seen_r   <= 1'b0;
      pbtn_r   <= '0;
      ovalid_r <= 1'b0;
      ax_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sadv_pkg::RegGain:  gain_r  <= cfg_data;
          sadv_pkg::RegSlack: slack_r <= cfg_data[2:0];
          sadv_pkg::RegClamp: clamp_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        sadv_pkg::ST_IDLE:
          if (accept) begin
            ax_r <= '0;
            if (!seen_r) begin
              seen_r   <= 1'b1;
              pstamp_r <= in_data.stamp;
            end
            if (!calib_done) begin
              calib_r <= calib_r + CCW'(1);
              begin
                logic [15:0] m [6];
                m[0] = in_data.axis_x[15]  ? 16'(-in_data.axis_x)  : 16'(in_data.axis_x);
                m[1] = in_data.axis_y[15]  ? 16'(-in_data.axis_y)  : 16'(in_data.axis_y);
                m[2] = in_data.axis_z[15]  ? 16'(-in_data.axis_z)  : 16'(in_data.axis_z);
                m[3] = in_data.axis_rx[15] ? 16'(-in_data.axis_rx) : 16'(in_data.axis_rx);
                m[4] = in_data.axis_ry[15] ? 16'(-in_data.axis_ry) : 16'(in_data.axis_ry);
                m[5] = in_data.axis_rz[15] ? 16'(-in_data.axis_rz) : 16'(in_data.axis_rz);
                for (int i = 0; i < 6; i++)
                  if (m[i] > peak_r[i]) peak_r[i] <= m[i];
              end
              sq_acc_r <= '0;
            end else begin
              dt_r     <= in_data.stamp - (seen_r ? pstamp_r : in_data.stamp);
              passed_r <= 1'b0;
              rot_r    <= 1'b0;
              tr_acc_r <= '0;
            end
          end
        sadv_pkg::ST_SQ_WAIT:
          if (!mul_busy) begin
            sq_acc_r <= sq_acc_r + mul_p[33:0];
            ax_r     <= ax_r + 3'd1;
          end
        sadv_pkg::ST_SQRT_START:
          if (sq_acc_r <= sadv_pkg::NoiseSqLimit) begin
            for (int i = 0; i < 6; i++) peak_r[i] <= sadv_pkg::FakePeak[15:0];
            sq_acc_r <= FakeSq;
          end
        sadv_pkg::ST_SQRT_WAIT:
          if (!sq_busy) norm_r <= sq_root[16:0];
        sadv_pkg::ST_AXIS: begin
          neg_r <= cur_ax[15];
          if (pass) begin
            passed_r <= 1'b1;
            if (ax_r >= 3'd3) rot_r <= 1'b1;
          end
        end
        sadv_pkg::ST_DIV_WAIT:
          if (!div_busy) begin
            rate_r[ax_r < 3'd6 ? ax_r : 3'd5] <= sat_rate;
            ax_r <= (ax_r == 3'd5) ? 3'd3 : ax_r + 3'd1;
          end
        sadv_pkg::ST_TR_WAIT:
          if (!mul_busy) begin
            tr_acc_r <= tr_acc_r + 66'(mul_p);
            ax_r     <= ax_r + 3'd1;
          end
        sadv_pkg::ST_TRSQ_WAIT:
          if (!sq_busy && !ovalid_r) begin
            res_r.move_x <= rate_r[0];
            res_r.move_y <= rate_r[1];
            res_r.move_z <= rate_r[2];
            res_r.turn_x <= rate_r[3];
            res_r.turn_y <= rate_r[4];
            res_r.turn_z <= rate_r[5];
            res_r.turn_rate <= (sq_root > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq_root[31:0];
            res_r.stick_ok <= dt_r != 32'd0 && passed_r;
            res_r.rotation_ok <= rot_r;
            res_r.button_presses <= item_r.button_levels & BtnMask & ~pbtn_r;
            pbtn_r   <= item_r.button_levels & BtnMask;
            pstamp_r <= item_r.stamp;
          end
        sadv_pkg::ST_OUT:
          if (!ovalid_r || !out_stall) ovalid_r <= 1'b1;
        default: ;
      endcase
    end
    if (accept) item_r <= in_data;
  end

  assign in_stall  = !rst_n || state_r != sadv_pkg::ST_IDLE;
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  `AST_CLK(a_no_accept_busy, !(in_valid && !in_stall && state_r != sadv_pkg::ST_IDLE),
           "input accepted while busy")
  `AST_NEXT(a_out_sets_valid, state_r == sadv_pkg::ST_OUT && !ovalid_r, ovalid_r,
            "result not presented")
  `AST_CLK(a_calib_bound, calib_r <= CCW'(CAL_SAMPLES), "calibration count overrun")
  `AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
            "stalled result changed")
endmodule

// ----- verif/tb_six_axis_deadband_velocity.sv -----
`timescale 1ns / 100ps

module tb_six_axis_deadband_velocity;

  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned END_CYCLES    = 700;
  localparam int unsigned HOLD_CYCLES   = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sadv_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sadv_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = sadv_pkg::RegGain;
  logic [15:0]         cfg_data = '0;

  six_axis_deadband_velocity i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block's registers and state
  int unsigned gain_r = 1, slack_r = 2, clamp_r = 2;
  int unsigned peaks[6];
  int unsigned cal_cnt = 0;
  int unsigned norm_r = 0;
  bit [31:0]   last_stamp = '0;
  bit          stamp_valid = 1'b0;
  bit [15:0]   last_btn = '0;
  sadv_pkg::out_item_t rate_q[$];
  int          mism = 0;

  // stimulus state
  bit [31:0] cur_stamp = 32'h1000;
  int        burst_left = 0;
  int        hold_req_id = 0;

  function automatic bit [63:0] root64(bit [63:0] v);
    bit [63:0] res, t;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  task automatic predict_rate(sadv_pkg::in_item_t it);
    longint    ax[6];
    longint    rt[6];
    longint    thr, lim, m, f, r;
    bit [31:0] dt;
    bit        pass, rpass;
    bit [63:0] s;
    sadv_pkg::out_item_t e;
    ax[0] = it.axis_x;  ax[1] = it.axis_y;  ax[2] = it.axis_z;
    ax[3] = it.axis_rx; ax[4] = it.axis_ry; ax[5] = it.axis_rz;
    if (!stamp_valid) begin
      last_stamp = it.stamp;
      stamp_valid = 1'b1;
    end
    if (cal_cnt < sadv_pkg::CalibSamples) begin
      cal_cnt++;
      for (int i = 0; i < 6; i++) begin
        m = ax[i] < 0 ? -ax[i] : ax[i];
        if (m > peaks[i]) peaks[i] = 32'(m);
      end
      if (cal_cnt == sadv_pkg::CalibSamples) begin
        s = '0;
        foreach (peaks[i]) s += 64'(peaks[i]) * 64'(peaks[i]);
        // quiet stick: substitute a fixed noise floor
        if (s <= 64'(sadv_pkg::NoiseSqLimit)) begin
          s = '0;
          foreach (peaks[i]) begin
            peaks[i] = 32'(sadv_pkg::FakePeak);
            s += 64'(peaks[i]) * 64'(peaks[i]);
          end
        end
        norm_r = 32'(root64(s) & 64'h1ffff);
      end
      return;
    end
    dt = it.stamp - last_stamp;
    thr = longint'(slack_r) * longint'(norm_r);
    lim = longint'(clamp_r) * thr;
    pass = 1'b0;
    rpass = 1'b0;
    for (int i = 0; i < 6; i++) begin
      m = ax[i] < 0 ? -ax[i] : ax[i];
      f = 0;
      if (m > thr) begin
        pass = 1'b1;
        if (i >= 3) rpass = 1'b1;
        if (m > lim) m = lim;
        f = ax[i] < 0 ? -m : m;
      end
      rt[i] = 0;
      if (dt != 0) begin
        r = (longint'(gain_r) * f) / longint'(dt);
        if (r > 64'sh7fffffff) r = 64'sh7fffffff;
        if (r < -64'sh80000000) r = -64'sh80000000;
        rt[i] = r;
      end
    end
    s = '0;
    for (int i = 3; i < 6; i++) begin
      m = rt[i] < 0 ? -rt[i] : rt[i];
      s += 64'(m) * 64'(m);
    end
    s = root64(s);
    e.move_x = rt[0][31:0]; e.move_y = rt[1][31:0]; e.move_z = rt[2][31:0];
    e.turn_x = rt[3][31:0]; e.turn_y = rt[4][31:0]; e.turn_z = rt[5][31:0];
    e.turn_rate = s > 64'hffffffff ? 32'hffffffff : s[31:0];
    e.stick_ok = (dt != 0) && pass;
    e.rotation_ok = rpass;
    e.button_presses = it.button_levels & ~last_btn;
    last_btn = it.button_levels;
    last_stamp = it.stamp;
    rate_q.push_back(e);
  endtask

  // called just after a rising edge
  task automatic send_sample(sadv_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_rate(it);
  endtask

  // bursts of random length with random gaps between them
  task automatic send_paced(sadv_pkg::in_item_t it);
    int gap;
    send_sample(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(0, 9));
      gap = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 40));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk);
    // calibration beats give no result, so let the block settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(bit [15:0] gain, bit [2:0] slack, bit [2:0] clamp);
    cfg_we <= 1'b1; cfg_index <= sadv_pkg::RegGain; cfg_data <= gain;
    @(posedge clk);
    cfg_index <= sadv_pkg::RegSlack; cfg_data <= 16'(slack);
    @(posedge clk);
    cfg_index <= sadv_pkg::RegClamp; cfg_data <= 16'(clamp);
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_r = 32'(gain); slack_r = 32'(slack); clamp_r = 32'(clamp);
  endtask

  function automatic sadv_pkg::in_item_t make_sample(bit [31:0] dt, bit [15:0] axv,
                                                     bit [15:0] btn);
    sadv_pkg::in_item_t it;
    cur_stamp += dt;
    it.axis_x = axv; it.axis_y = axv; it.axis_z = axv;
    it.axis_rx = axv; it.axis_ry = axv; it.axis_rz = axv;
    it.stamp = cur_stamp;
    it.button_levels = btn;
    return it;
  endfunction

  function automatic bit [15:0] rand_axis();
    int thr, w;
    thr = int'(slack_r * norm_r);
    w = 3 * thr + 20;
    if (w > 32767) w = 32767;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 65535));
      5: return $urandom_range(0, 1) ? 16'(thr) : -16'(thr);
      default: return 16'($signed($urandom_range(0, 2 * w)) - w);
    endcase
  endfunction

  function automatic sadv_pkg::in_item_t rand_sample();
    sadv_pkg::in_item_t it;
    bit [31:0] dt;
    case ($urandom_range(0, 19))
      0, 1: dt = '0;
      2: dt = $urandom();
      3: dt = 32'hffff0000 + $urandom_range(0, 65535);
      4, 5: dt = $urandom_range(1, 3);
      default: dt = $urandom_range(1, 2000);
    endcase
    cur_stamp += dt;
    it.axis_x = rand_axis(); it.axis_y = rand_axis(); it.axis_z = rand_axis();
    it.axis_rx = rand_axis(); it.axis_ry = rand_axis(); it.axis_rz = rand_axis();
    it.stamp = cur_stamp;
    it.button_levels = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic test_calibration();
    sadv_pkg::in_item_t it;
    bit       quiet;
    int       amp;
    quiet = 1'($urandom_range(0, 1));
    // a quiet stick falls back to the fixed noise floor
    amp = quiet ? 100 : 1500;
    for (int n = 0; n < sadv_pkg::CalibSamples; n++) begin
      it = make_sample($urandom_range(1, 50), '0, 16'($urandom_range(0, 65535)));
      it.axis_x = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      it.axis_y = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      it.axis_z = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      it.axis_rx = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      it.axis_ry = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      it.axis_rz = 16'($signed($urandom_range(0, 2 * amp)) - amp);
      send_paced(it);
    end
    drain();
  endtask

  task automatic test_directed();
    sadv_pkg::in_item_t it;
    bit [15:0] thr;
    write_regs(16'd1, 3'd2, 3'd2);
    thr = 16'(slack_r * norm_r);
    send_paced(make_sample(32'd10, 16'h0000, 16'hffff));
    send_paced(make_sample(32'd1, 16'h7fff, 16'h0000));
    send_paced(make_sample(32'd1, 16'h8000, 16'hffff));
    send_paced(make_sample(32'd0, 16'h7fff, 16'hffff));
    send_paced(make_sample(32'hffffffff, 16'h7fff, 16'h5555));
    send_paced(make_sample(32'd5, thr, 16'haaaa));
    send_paced(make_sample(32'd5, thr + 16'd1, 16'hffff));
    send_paced(make_sample(32'd5, -thr - 16'd1, 16'h0000));
    send_paced(make_sample(32'd5, 16'(2 * thr + 1), 16'h0001));
    it = make_sample(32'd7, '0, 16'h8000);
    it.axis_rz = -thr - 16'd3;
    send_paced(it);
    it = make_sample(32'd7, '0, 16'h0000);
    it.axis_x = thr + 16'd9;
    send_paced(it);
    drain();
    write_regs(16'hffff, 3'd7, 3'd7);
    send_paced(make_sample(32'd1, 16'h7fff, 16'h1234));
    send_paced(make_sample(32'd1, 16'h8000, 16'h4321));
    send_paced(make_sample(32'd3, 16'h8000, 16'h0000));
    drain();
    write_regs(16'h0000, 3'd0, 3'd0);
    send_paced(make_sample(32'd1, 16'h0001, 16'hffff));
    send_paced(make_sample(32'd1, 16'h0000, 16'h0000));
    drain();
    write_regs(16'hffff, 3'd0, 3'd7);
    send_paced(make_sample(32'd1, 16'h8000, 16'hffff));
    send_paced(make_sample(32'd2, 16'h0001, 16'h0000));
    drain();
    write_regs(16'd300, 3'd1, 3'd0);
    send_paced(make_sample(32'd1, 16'h7fff, 16'h00ff));
    drain();
  endtask

  task automatic test_random_phase(int count);
    bit [15:0] gain;
    case ($urandom_range(0, 4))
      0: gain = 16'hffff;
      1: gain = 16'd1;
      2: gain = 16'($urandom_range(0, 255));
      default: gain = 16'($urandom_range(0, 65535));
    endcase
    write_regs(gain, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    repeat (count) send_paced(rand_sample());
    drain();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_long_hold();
    write_regs(16'($urandom_range(1, 65535)), 3'($urandom_range(1, 7)),
               3'($urandom_range(1, 7)));
    hold_req_id++;
    repeat (12) send_sample(rand_sample());
    drain();
  endtask

  // receiver: its own stall pattern plus the long hold-off on request
  int hold_left = 0;
  int hold_seen = 0;
  int stall_pct = 0;
  int pat_cnt = 0;
  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 1;
    if (pat_cnt % 500 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 70;
        default: stall_pct <= 95;
      endcase
    end
    if (hold_req_id != hold_seen) begin
      hold_seen <= hold_req_id;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(string name, bit [31:0] e, bit [31:0] a);
    if (e !== a) begin
      mism++;
      if (mism <= 10) $display("mismatch %s: expected %h, got %h", name, e, a);
    end
  endtask

  always @(posedge clk) begin
    sadv_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rate_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        e = rate_q.pop_front();
        check_field("move_x", e.move_x, out_data.move_x);
        check_field("move_y", e.move_y, out_data.move_y);
        check_field("move_z", e.move_z, out_data.move_z);
        check_field("turn_x", e.turn_x, out_data.turn_x);
        check_field("turn_y", e.turn_y, out_data.turn_y);
        check_field("turn_z", e.turn_z, out_data.turn_z);
        check_field("turn_rate", e.turn_rate, out_data.turn_rate);
        check_field("stick_ok", 32'(e.stick_ok), 32'(out_data.stick_ok));
        check_field("rotation_ok", 32'(e.rotation_ok), 32'(out_data.rotation_ok));
        check_field("button_presses", 32'(e.button_presses),
                    32'(out_data.button_presses));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calibration();
    test_directed();
    test_long_hold();
    for (int p = 0; p < 5; p++) test_random_phase(255);
    test_long_hold();
    in_valid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mism == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
